/* rtl/core/ewpd_pkg.sv */
// Package with the shared types, codes and character helpers of the encoded-word decoder.
`default_nettype none

package ewpd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } ewpd_kind_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_EQ   = 2'd1,
    ESC_HI   = 2'd2
  } ewpd_esc_t;

  localparam logic [7:0] LOWER_CASE_BIT = 8'h20;
  localparam logic [7:0] MODE_Q         = 8'h71;
  localparam logic [7:0] MODE_B         = 8'h62;
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_QMARK     = 8'h3f;
  localparam logic [7:0] CHAR_EQUALS    = 8'h3d;
  localparam logic [7:0] CHAR_UNDERLINE = 8'h5f;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_CR        = 8'h0d;
  localparam logic [7:0] CHAR_LF        = 8'h0a;
  localparam logic [7:0] RESET_LETTER   = 8'h71;
  localparam logic [5:0] SEXTET_PLUS    = 6'd62;
  localparam logic [5:0] SEXTET_SLASH   = 6'd63;

  typedef struct packed {
    ewpd_esc_t   esc_phase;
    logic [3:0]  high_nibble;
    logic [11:0] bit_buffer;
    logic [2:0]  bit_count;
    logic        word_closed;
  } ewpd_state_t;

  typedef struct packed {
    ewpd_kind_t  kind;
    logic [7:0]  data;
    logic [11:0] length;
  } ewpd_result_t;

  // Returns a valid flag above the 4-bit digit value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      case (c) inside
        [8'h30:8'h39]: begin
          d = c - 8'h30;
          hex_value = {1'b1, d[3:0]};
        end
        [8'h61:8'h66]: begin
          d = c - 8'h57;
          hex_value = {1'b1, d[3:0]};
        end
        [8'h41:8'h46]: begin
          d = c - 8'h37;
          hex_value = {1'b1, d[3:0]};
        end
        default: hex_value = 5'd0;
      endcase
    end
  endfunction

  // Returns a valid flag above the 6-bit base64 symbol value.
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      case (c) inside
        [8'h41:8'h5a]: begin
          d = c - 8'h41;
          sextet_value = {1'b1, d[5:0]};
        end
        [8'h61:8'h7a]: begin
          d = c - 8'h47;
          sextet_value = {1'b1, d[5:0]};
        end
        [8'h30:8'h39]: begin
          d = c + 8'h04;
          sextet_value = {1'b1, d[5:0]};
        end
        8'h2b:   sextet_value = {1'b1, SEXTET_PLUS};
        8'h2f:   sextet_value = {1'b1, SEXTET_SLASH};
        default: sextet_value = 7'd0;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ewpd_if.sv */
// Valid/ready channel interfaces for the input bytes and the decoded results.
`default_nettype none

interface ewpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       word_start;

  modport source (output valid, output in_byte, output word_start, input ready);
  modport sink (input valid, input in_byte, input word_start, output ready);
endinterface

interface ewpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [11:0] out_length;

  modport source (output valid, output out_kind, output out_byte, output out_length,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_length,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/ewpd_step.sv */
// Next-state and result logic for one payload byte of an encoded word.
`default_nettype none

module ewpd_step #(
  parameter int unsigned MAX_OUT_LEN = 4095,
  parameter int unsigned CNT_W       = 12
) (
  input  ewpd_pkg::ewpd_state_t  st,
  input  logic [CNT_W-1:0]       cnt,
  input  logic [7:0]             in_byte,
  input  logic                   word_start,
  input  logic [7:0]             letter,
  output ewpd_pkg::ewpd_state_t  st_nxt,
  output logic [CNT_W-1:0]       cnt_nxt,
  output logic                   res_valid,
  output ewpd_pkg::ewpd_result_t res
);

  ewpd_pkg::ewpd_state_t s;
  logic [CNT_W-1:0]      c;
  logic [7:0]            mode;
  logic [4:0]            hex;
  logic [6:0]            sext;
  logic [3:0]            bits_sum;
  logic [3:0]            bits_left;
  logic [11:0]           buf_new;
  logic                  data_hit;
  logic [7:0]            data_val;

  assign mode = letter | ewpd_pkg::LOWER_CASE_BIT;
  assign hex  = ewpd_pkg::hex_value(in_byte);
  assign sext = ewpd_pkg::sextet_value(in_byte);

  always_comb begin
    s = st;
    c = cnt;
    if (word_start) begin
      s.esc_phase   = ewpd_pkg::ESC_IDLE;
      s.high_nibble = 4'd0;
      s.bit_buffer  = 12'd0;
      s.bit_count   = 3'd0;
      s.word_closed = 1'b0;
      c = '0;
    end
    st_nxt    = s;
    cnt_nxt   = c;
    res_valid = 1'b0;
    res       = '{kind: ewpd_pkg::KIND_DATA, data: 8'd0, length: 12'd0};
    data_hit  = 1'b0;
    data_val  = 8'd0;
    bits_sum  = {1'b0, s.bit_count} + 4'd6;
    bits_left = bits_sum - 4'd8;
    buf_new   = {s.bit_buffer[5:0], sext[5:0]};

    if (!s.word_closed) begin
      if (mode == ewpd_pkg::MODE_Q) begin
        case (s.esc_phase)
          ewpd_pkg::ESC_EQ: begin
            if (in_byte == ewpd_pkg::CHAR_CR || in_byte == ewpd_pkg::CHAR_LF) begin
              st_nxt.esc_phase = ewpd_pkg::ESC_IDLE;
            end else if (hex[4]) begin
              st_nxt.high_nibble = hex[3:0];
              st_nxt.esc_phase   = ewpd_pkg::ESC_HI;
            end else begin
              st_nxt.word_closed = 1'b1;
              res_valid          = 1'b1;
              res.kind           = ewpd_pkg::KIND_ERROR;
            end
          end
          ewpd_pkg::ESC_HI: begin
            if (hex[4]) begin
              st_nxt.esc_phase = ewpd_pkg::ESC_IDLE;
              data_hit         = 1'b1;
              data_val         = {s.high_nibble, hex[3:0]};
            end else begin
              st_nxt.word_closed = 1'b1;
              res_valid          = 1'b1;
              res.kind           = ewpd_pkg::KIND_ERROR;
            end
          end
          default: begin
            if (in_byte == ewpd_pkg::CHAR_NUL || in_byte == ewpd_pkg::CHAR_QMARK) begin
              st_nxt.word_closed = 1'b1;
              res_valid          = 1'b1;
              res.kind           = ewpd_pkg::KIND_END;
              res.length         = 12'(c);
            end else if (in_byte == ewpd_pkg::CHAR_EQUALS) begin
              st_nxt.esc_phase = ewpd_pkg::ESC_EQ;
            end else if (in_byte == ewpd_pkg::CHAR_UNDERLINE) begin
              data_hit = 1'b1;
              data_val = ewpd_pkg::CHAR_SPACE;
            end else begin
              data_hit = 1'b1;
              data_val = in_byte;
            end
          end
        endcase
      end else if (mode == ewpd_pkg::MODE_B) begin
        if (in_byte == ewpd_pkg::CHAR_NUL || in_byte == ewpd_pkg::CHAR_QMARK) begin
          st_nxt.word_closed = 1'b1;
          res_valid          = 1'b1;
          res.kind           = ewpd_pkg::KIND_END;
          res.length         = 12'(c);
        end else if (sext[6]) begin
          st_nxt.bit_buffer = buf_new;
          if (bits_sum >= 4'd8) begin
            st_nxt.bit_count = bits_left[2:0];
            data_hit         = 1'b1;
            data_val         = 8'(buf_new >> bits_left);
          end else begin
            st_nxt.bit_count = bits_sum[2:0];
          end
        end
      end else begin
        st_nxt.word_closed = 1'b1;
        res_valid          = 1'b1;
        res.kind           = ewpd_pkg::KIND_ERROR;
      end
    end

    if (data_hit) begin
      res_valid = 1'b1;
      res.data  = data_val;
      if (c < CNT_W'(MAX_OUT_LEN)) begin
        cnt_nxt = c + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/encoded_word_payload_decoder_core.sv */
// Top level of the encoded-word payload decoder with its beat pipeline.
// A result beat is registered in the input stage, decoded by the step logic and
// registered in the result stage, where it is held until the receiver takes it.
// Throughput: one input beat per cycle; a stalled result holds both stages.
// Reset (rst_n low, synchronous) empties both stages, closes the word, clears
// the decoding state and sets the encoding letter to 'q'.
`default_nettype none

module encoded_word_payload_decoder_core #(
  parameter int unsigned MAX_OUT_LEN = 4095
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  ewpd_in_if.sink           in_bus,
  ewpd_out_if.source        out_bus
);

  localparam int unsigned CNT_W = $clog2(MAX_OUT_LEN + 1);

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_start_r;
  logic                   out_valid_r;
  ewpd_pkg::ewpd_result_t out_res_r;
  ewpd_pkg::ewpd_state_t  state_r;
  ewpd_pkg::ewpd_state_t  state_nxt;
  logic [CNT_W-1:0]       byte_count_r;
  logic [CNT_W-1:0]       byte_count_nxt;
  logic [7:0]             letter_r;
  logic                   res_valid;
  ewpd_pkg::ewpd_result_t res;
  logic                   advance;

  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = advance || !s1_valid_r;

  ewpd_step #(
    .MAX_OUT_LEN (MAX_OUT_LEN),
    .CNT_W       (CNT_W)
  ) u_step (
    .st         (state_r),
    .cnt        (byte_count_r),
    .in_byte    (s1_byte_r),
    .word_start (s1_start_r),
    .letter     (letter_r),
    .st_nxt     (state_nxt),
    .cnt_nxt    (byte_count_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      letter_r     <= ewpd_pkg::RESET_LETTER;
      byte_count_r <= '0;
      state_r      <= '{esc_phase: ewpd_pkg::ESC_IDLE, high_nibble: 4'd0,
                        bit_buffer: 12'd0, bit_count: 3'd0, word_closed: 1'b1};
    end else begin
      if (cfg_wr_en) begin
        letter_r <= cfg_wr_data;
      end
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r && res_valid;
        if (s1_valid_r) begin
          state_r      <= state_nxt;
          byte_count_r <= byte_count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready) begin
      s1_byte_r  <= in_bus.in_byte;
      s1_start_r <= in_bus.word_start;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_kind   = out_res_r.kind;
  assign out_bus.out_byte   = out_res_r.data;
  assign out_bus.out_length = out_res_r.length;

`ifndef SYNTHESIS
  a_close_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && res_valid &&
     (res.kind == ewpd_pkg::KIND_END || res.kind == ewpd_pkg::KIND_ERROR))
    |=> state_r.word_closed)
    else $error("Word still open after an end or error beat.");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_W'(MAX_OUT_LEN))
    else $error("Byte count beyond its saturation limit.");

  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == ewpd_pkg::KIND_DATA) |-> out_res_r.length == 12'd0)
    else $error("Data beat carries a nonzero length.");

  a_nondata_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind != ewpd_pkg::KIND_DATA) |-> out_res_r.data == 8'd0)
    else $error("End or error beat carries a nonzero byte.");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_start_r))
    else $error("Input stage changed while the result stage was stalled.");
`endif

endmodule

`default_nettype wire

/* test/encoded_word_payload_decoder_core_test.sv */
// Self-checking testbench for the encoded-word payload decoder core.
`timescale 1ns / 1ps

module encoded_word_payload_decoder_core_test;

  localparam int MAX_LEN        = 4095;
  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BEATS    = 45;

  class payload_scoreboard;
    logic [7:0]             letter;
    ewpd_pkg::ewpd_esc_t    esc;
    logic [3:0]             hi_nib;
    logic [11:0]            bits;
    int                     nbits;
    int                     decoded;
    bit                     closed;
    ewpd_pkg::ewpd_result_t decoded_results[$];
    int                     beats_in;
    int                     errors;

    function new();
      letter   = ewpd_pkg::RESET_LETTER;
      esc      = ewpd_pkg::ESC_IDLE;
      hi_nib   = '0;
      bits     = '0;
      nbits    = 0;
      decoded  = 0;
      closed   = 1'b1;
      beats_in = 0;
      errors   = 0;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function int b64_symbol(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
    endfunction

    function void push_result(ewpd_pkg::ewpd_kind_t k, logic [7:0] d, logic [11:0] n);
      ewpd_pkg::ewpd_result_t r;
      r.kind   = k;
      r.data   = d;
      r.length = n;
      decoded_results.push_back(r);
    endfunction

    function void push_data(logic [7:0] d);
      if (decoded < MAX_LEN) decoded++;
      push_result(ewpd_pkg::KIND_DATA, d, '0);
    endfunction

    function void push_error();
      closed = 1'b1;
      push_result(ewpd_pkg::KIND_ERROR, '0, '0);
    endfunction

    function void note_input(logic [7:0] c, logic s);
      logic [7:0] mode;
      int         h;
      beats_in++;
      mode = letter | ewpd_pkg::LOWER_CASE_BIT;
      if (s) begin
        esc     = ewpd_pkg::ESC_IDLE;
        hi_nib  = '0;
        bits    = '0;
        nbits   = 0;
        decoded = 0;
        closed  = 1'b0;
      end
      if (closed) return;
      if (mode == ewpd_pkg::MODE_Q) begin
        case (esc)
          ewpd_pkg::ESC_EQ: begin
            if (c == ewpd_pkg::CHAR_CR || c == ewpd_pkg::CHAR_LF) begin
              esc = ewpd_pkg::ESC_IDLE;
            end else begin
              h = hex_digit(c);
              if (h < 0) begin
                push_error();
              end else begin
                hi_nib = h[3:0];
                esc    = ewpd_pkg::ESC_HI;
              end
            end
          end
          ewpd_pkg::ESC_HI: begin
            h = hex_digit(c);
            if (h < 0) begin
              push_error();
            end else begin
              esc = ewpd_pkg::ESC_IDLE;
              push_data({hi_nib, h[3:0]});
            end
          end
          default: begin
            if (c == ewpd_pkg::CHAR_NUL || c == ewpd_pkg::CHAR_QMARK) begin
              closed = 1'b1;
              push_result(ewpd_pkg::KIND_END, '0, decoded[11:0]);
            end else if (c == ewpd_pkg::CHAR_EQUALS) begin
              esc = ewpd_pkg::ESC_EQ;
            end else if (c == ewpd_pkg::CHAR_UNDERLINE) begin
              push_data(ewpd_pkg::CHAR_SPACE);
            end else begin
              push_data(c);
            end
          end
        endcase
      end else if (mode == ewpd_pkg::MODE_B) begin
        if (c == ewpd_pkg::CHAR_NUL || c == ewpd_pkg::CHAR_QMARK) begin
          closed = 1'b1;
          push_result(ewpd_pkg::KIND_END, '0, decoded[11:0]);
        end else begin
          h = b64_symbol(c);
          if (h >= 0) begin
            bits  = {bits[5:0], h[5:0]};
            nbits = nbits + 6;
            if (nbits >= 8) begin
              nbits = nbits - 8;
              push_data(8'(bits >> nbits));
            end
          end
        end
      end else begin
        push_error();
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic [11:0] length);
      ewpd_pkg::ewpd_result_t want;
      if (decoded_results.size() == 0) begin
        report($sformatf("unexpected beat kind %0d byte %02h length %0d", kind, data, length));
        return;
      end
      want = decoded_results.pop_front();
      if (kind != want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (data != want.data)
        report($sformatf("byte %02h, expected %02h", data, want.data));
      if (length != want.length)
        report($sformatf("length %0d, expected %0d", length, want.length));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  bit         hold_req = 1'b0;
  int         burst_left = 20;
  int         idle_cycles = 0;

  payload_scoreboard board = new();

  ewpd_in_if  in_ch ();
  ewpd_out_if out_ch ();

  encoded_word_payload_decoder_core #(
    .MAX_OUT_LEN (MAX_LEN)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bus      (in_ch),
    .out_bus     (out_ch)
  );

  always #6 clk = ~clk;

  task automatic send_beat(input logic [7:0] b, input logic s);
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.word_start <= s;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(b, s);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.decoded_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_letter(input logic [7:0] l);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= l;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.letter = l;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return "0" + v;
    if ($urandom_range(0, 1)) return 8'("A" + v - 10);
    return 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 26) return "A" + v;
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == ewpd_pkg::SEXTET_PLUS) return "+";
    return "/";
  endfunction

  function automatic logic [7:0] q_plain();
    logic [7:0] v;
    do begin
      v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7e));
    end while (v == ewpd_pkg::CHAR_NUL || v == ewpd_pkg::CHAR_QMARK ||
               v == ewpd_pkg::CHAR_EQUALS);
    return v;
  endfunction

  function automatic logic [7:0] b64_filler();
    logic [7:0] v;
    if ($urandom_range(0, 1)) return ewpd_pkg::CHAR_EQUALS;
    do begin
      v = 8'($urandom);
    end while (board.b64_symbol(v) >= 0 || v == ewpd_pkg::CHAR_NUL ||
               v == ewpd_pkg::CHAR_QMARK);
    return v;
  endfunction

  function automatic logic [7:0] word_end();
    return $urandom_range(0, 1) ? ewpd_pkg::CHAR_QMARK : ewpd_pkg::CHAR_NUL;
  endfunction

  task automatic noise_beats(input int n);
    int k;
    for (k = 0; k < n; k++) send_beat(8'($urandom), $urandom_range(0, 9) == 0);
  endtask

  task automatic q_word(input int tokens);
    logic       s;
    int         k;
    int         pick;
    logic [7:0] v;
    s = 1'b1;
    for (k = 0; k < tokens; k++) begin
      pick = $urandom_range(0, 99);
      v    = 8'($urandom);
      if (pick < 55) begin
        send_beat(q_plain(), s);
      end else if (pick < 80) begin
        send_beat(ewpd_pkg::CHAR_EQUALS, s);
        send_beat(hex_char(v[7:4]), 1'b0);
        send_beat(hex_char(v[3:0]), 1'b0);
      end else if (pick < 88) begin
        send_beat(ewpd_pkg::CHAR_UNDERLINE, s);
      end else if (pick < 94) begin
        send_beat(ewpd_pkg::CHAR_EQUALS, s);
        send_beat(v[0] ? ewpd_pkg::CHAR_CR : ewpd_pkg::CHAR_LF, 1'b0);
      end else begin
        send_beat(ewpd_pkg::CHAR_EQUALS, s);
        if (v[0]) send_beat(hex_char(v[7:4]), 1'b0);
        send_beat(8'($urandom), 1'b0);
      end
      s = 1'b0;
    end
    send_beat(word_end(), s);
  endtask

  task automatic b64_word(input int tokens);
    logic s;
    int   k;
    s = 1'b1;
    for (k = 0; k < tokens; k++) begin
      if ($urandom_range(0, 99) < 85) send_beat(b64_char(6'($urandom_range(0, 63))), s);
      else send_beat(b64_filler(), s);
      s = 1'b0;
    end
    send_beat(word_end(), s);
  endtask

  initial begin : receiver
    int stretch;
    int duty;
    out_ch.ready <= 1'b0;
    forever begin
      stretch = $urandom_range(5, 60);
      case ($urandom_range(0, 3))
        0:       duty = 100;
        1:       duty = 70;
        2:       duty = 40;
        default: duty = 15;
      endcase
      repeat (stretch) begin
        @(posedge clk);
        if (hold_req) begin
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(1, 100) <= duty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.out_kind, out_ch.out_byte, out_ch.out_length);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] plan [12];
    logic [7:0] letter;
    logic [7:0] mode;
    int         p;
    int         first_beat;
    int         pick;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= '0;
    in_ch.word_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat("A", 1'b1);
    send_beat("=", 1'b0);
    send_beat("4", 1'b0);
    send_beat("f", 1'b0);
    send_beat("=", 1'b0);
    send_beat("0", 1'b0);
    send_beat("E", 1'b0);
    send_beat("_", 1'b0);
    send_beat("=", 1'b0);
    send_beat(ewpd_pkg::CHAR_CR, 1'b0);
    send_beat("=", 1'b0);
    send_beat(ewpd_pkg::CHAR_LF, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(ewpd_pkg::CHAR_QMARK, 1'b0);
    send_beat("Z", 1'b0);
    send_beat(ewpd_pkg::CHAR_NUL, 1'b1);
    send_beat("=", 1'b1);
    send_beat("G", 1'b0);
    send_beat("x", 1'b0);
    send_beat("=", 1'b1);
    send_beat("7", 1'b0);
    send_beat(ewpd_pkg::CHAR_QMARK, 1'b0);
    send_beat("=", 1'b1);
    send_beat(ewpd_pkg::CHAR_NUL, 1'b0);
    send_beat(8'hff, 1'b1);
    send_beat("=", 1'b1);

    set_letter("B");
    send_beat("T", 1'b1);
    send_beat("W", 1'b0);
    send_beat("F", 1'b0);
    send_beat("u", 1'b0);
    send_beat("+", 1'b0);
    send_beat("/", 1'b0);
    send_beat("=", 1'b0);
    send_beat("9", 1'b0);
    send_beat("z", 1'b0);
    send_beat("/", 1'b0);
    send_beat(ewpd_pkg::CHAR_QMARK, 1'b0);
    send_beat(ewpd_pkg::CHAR_QMARK, 1'b1);

    set_letter(8'h00);
    send_beat("x", 1'b1);
    send_beat("y", 1'b0);
    set_letter(8'hff);
    send_beat(ewpd_pkg::CHAR_NUL, 1'b1);

    plan = '{"q", "B", "Q", "b", 8'hff, "q", "b", 8'h00, "Q", "B", 8'h00, 8'h00};
    for (p = 0; p < 12; p++) begin
      letter = (p == 7 || p == 11) ? 8'($urandom) : plan[p];
      set_letter(letter);
      if (p == 3) hold_req = 1'b1;
      mode       = letter | ewpd_pkg::LOWER_CASE_BIT;
      first_beat = board.beats_in;
      while (board.beats_in - first_beat < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) noise_beats($urandom_range(1, 6));
        else if (mode == ewpd_pkg::MODE_B) b64_word($urandom_range(0, 16));
        else if (mode == ewpd_pkg::MODE_Q) q_word($urandom_range(0, 10));
        else q_word($urandom_range(0, 2));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ewpd_pkg.sv
rtl/core/ewpd_if.sv
rtl/core/ewpd_step.sv
rtl/core/encoded_word_payload_decoder_core.sv
test/encoded_word_payload_decoder_core_test.sv
